/* sv/s2dec_pkg.sv */
// ----------------------------------------------------------------------------
// s2dec_pkg
// Shared types, constants and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package s2dec_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // Status from the conversion unit to the control FSM
  typedef struct packed {
    logic done;  // one-cycle pulse, BCD result valid
    logic neg;   // input was negative
  } dab_stat_t;

  // Double-dabble digit correction
  function automatic logic [3:0] add3(input logic [3:0] d);
    add3 = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

/* sv/s2dec_dabble.sv */
// ----------------------------------------------------------------------------
// s2dec_dabble
// Bit-serial binary to BCD conversion of the magnitude of a signed value,
// one input bit per cycle (shift-and-add-3).
// ----------------------------------------------------------------------------
module s2dec_dabble #(
  parameter int VALUE_WIDTH = s2dec_pkg::VALUE_WIDTH_DEF,
  parameter int NDIG        = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [VALUE_WIDTH-1:0]   value_i,
  output logic [4*NDIG-1:0]        bcd_o,
  output s2dec_pkg::dab_stat_t     stat_o
);
  import s2dec_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q;
  logic                   done_q;
  logic                   neg_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [4*NDIG-1:0]      bcd_q;
  logic [4*NDIG-1:0]      bcd_adj;
  logic                   sign;

  assign sign = value_i[VALUE_WIDTH-1];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = add3(bcd_q[4*i +: 4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= sign;
        cnt_q  <= CNT_W'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Magnitude as unsigned: the most negative value maps onto itself, which
  // is its exact unsigned magnitude.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= sign ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_q <= {bcd_adj[4*NDIG-2:0], mag_q[VALUE_WIDTH-1]};
    end
  end

  assign bcd_o       = bcd_q;
  assign stat_o.done = done_q;
  assign stat_o.neg  = neg_q;

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per
// output transaction, most significant first, last character flagged.
// ----------------------------------------------------------------------------
// Sequence: after the input transaction the BCD converter runs, then leading
//   zero digits are dropped one per cycle, then the sign and digits go out.
// Throughput: one number at a time; the next input is taken once the last
//   character is in the output register.
// Reset: rst_ni asynchronous, active low; returns to idle, output empty.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = s2dec_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [s2dec_pkg::CHAR_W-1:0]  char_code_o,
  output logic                          last_o
);
  import s2dec_pkg::*;

  // Decimal digits needed for an unsigned VALUE_WIDTH-bit magnitude
  localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DCW   = $clog2(NDIG + 1);
  localparam int BCD_W = 4 * NDIG;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_TRIM = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [DCW-1:0]    dig_cnt_q, dig_cnt_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;

  logic              start;
  logic              out_free;
  logic [3:0]        top_dig;
  logic [BCD_W-1:0]  dab_bcd;
  dab_stat_t         dab_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign top_dig    = bcd_q[BCD_W-1 -: 4];

  s2dec_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .bcd_o   (dab_bcd),
    .stat_o  (dab_stat)
  );

  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (dab_stat.done) begin
          bcd_d     = dab_bcd;
          neg_d     = dab_stat.neg;
          dig_cnt_d = DCW'(NDIG);
          state_d   = ST_TRIM;
        end
      end
      ST_TRIM: begin
        // drop leading zeros, keep at least one digit
        if (top_dig == 4'd0 && dig_cnt_q != DCW'(1)) begin
          bcd_d     = {bcd_q[BCD_W-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - DCW'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          char_d      = CH_MINUS;
          last_d      = 1'b0;
          out_valid_d = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          char_d      = CH_ZERO + {2'b00, top_dig};
          last_d      = (dig_cnt_q == DCW'(1));
          out_valid_d = 1'b1;
          bcd_d       = {bcd_q[BCD_W-5:0], 4'd0};
          dig_cnt_d   = dig_cnt_q - DCW'(1);
          if (dig_cnt_q == DCW'(1)) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dig_cnt_q   <= dig_cnt_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule
